### hw/rtl/crd_pkg.sv
package crd_pkg;

  // Decoder phase: which byte of the cel is expected next.
  typedef enum logic [3:0] {
    PH_WIDTH  = 4'b0001,
    PH_HEIGHT = 4'b0010,
    PH_FLAGS  = 4'b0100,
    PH_RUNS   = 4'b1000
  } phase_t;

  // Result kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_RUN    = 1'b1;

  // Column counter limit; the counter saturates here.
  localparam logic [8:0] COLUMN_LIMIT = 9'd256;

endpackage

### hw/rtl/cel_rle_run_decoder_core.sv
// Cel run-length decoder. Takes one cel byte per word on the data channel: width, height
// and flags, then run bytes (low nibble count, high nibble colour, zero ends the row).
// The flags byte gives one header word; each run byte gives at most one run word, clipped
// to the cel width, and a row end gives a fill run in the transparent key over the rest
// of the row. The last word of a cel carries cel_done. Each byte is decoded combinationally
// between the input handshake and a single result register, so a byte can be accepted on
// every clock edge; data_stall is raised only while that result register is full and the
// result side stalls.
module cel_rle_run_decoder_core
  import crd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       kind,
  output logic [7:0] run_column,
  output logic [7:0] run_row,
  output logic [7:0] run_length,
  output logic [3:0] pixel_color,
  output logic [7:0] cel_width,
  output logic [7:0] cel_height,
  output logic       mirror_flag,
  output logic [2:0] mirror_source_loop,
  output logic       cel_done
);

  phase_t     phase, phase_next;
  logic [7:0] width_reg, width_reg_next;
  logic [7:0] height_reg, height_reg_next;
  logic [3:0] key_reg, key_reg_next;
  logic [8:0] column, column_next;
  logic [7:0] row, row_next;

  logic       accept;
  logic       emit;
  logic       res_kind;
  logic [7:0] res_column;
  logic [7:0] res_row;
  logic [7:0] res_length;
  logic [3:0] res_color;
  logic       res_mflag;
  logic [2:0] res_mloop;
  logic       res_done;

  logic [3:0] count;
  logic [3:0] color;
  logic [7:0] room;
  logic [7:0] run_len;
  logic [9:0] column_sum;
  logic [7:0] fill_start;
  logic [7:0] fill_len;
  logic       last_row;

  assign data_stall = result_valid && result_stall;
  assign accept     = data_valid && !data_stall;

  assign count      = data_byte[3:0];
  assign color      = data_byte[7:4];
  assign room       = width_reg - column[7:0];
  assign column_sum = {1'b0, column} + {6'd0, count};
  assign fill_start = (column < {1'b0, width_reg}) ? column[7:0] : width_reg;
  assign fill_len   = width_reg - fill_start;
  assign last_row   = ({1'b0, row} + 9'd1) >= {1'b0, height_reg};

  always_comb begin
    // A run that starts at or beyond the width contributes nothing.
    if (column < {1'b0, width_reg}) begin
      run_len = ({4'd0, count} < room) ? {4'd0, count} : room;
    end else begin
      run_len = 8'd0;
    end
  end

  always_comb begin
    phase_next      = phase;
    width_reg_next  = width_reg;
    height_reg_next = height_reg;
    key_reg_next    = key_reg;
    column_next     = column;
    row_next        = row;
    emit            = 1'b0;
    res_kind        = KIND_RUN;
    res_column      = 8'd0;
    res_row         = row;
    res_length      = 8'd0;
    res_color       = 4'd0;
    res_mflag       = 1'b0;
    res_mloop       = 3'd0;
    res_done        = 1'b0;
    unique case (phase)
      PH_WIDTH: begin
        width_reg_next = data_byte;
        phase_next     = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        height_reg_next = data_byte;
        phase_next      = PH_FLAGS;
      end
      PH_FLAGS: begin
        key_reg_next = data_byte[3:0];
        column_next  = 9'd0;
        row_next     = 8'd0;
        phase_next   = (height_reg == 8'd0) ? PH_WIDTH : PH_RUNS;
        emit         = 1'b1;
        res_kind     = KIND_HEADER;
        res_row      = 8'd0;
        res_color    = data_byte[3:0];
        res_mflag    = data_byte[7];
        res_mloop    = data_byte[6:4];
        res_done     = (height_reg == 8'd0);
      end
      PH_RUNS: begin
        if (data_byte != 8'd0) begin
          column_next = (column_sum > {1'b0, COLUMN_LIMIT}) ? COLUMN_LIMIT : column_sum[8:0];
          emit        = (run_len != 8'd0);
          res_column  = column[7:0];
          res_length  = run_len;
          res_color   = color;
        end else begin
          // End of row: fill the remainder with the key. The last row always reports.
          emit        = (fill_len != 8'd0) || last_row;
          res_column  = fill_start;
          res_length  = fill_len;
          res_color   = key_reg;
          res_done    = last_row;
          column_next = 9'd0;
          if (last_row) begin
            row_next   = 8'd0;
            phase_next = PH_WIDTH;
          end else begin
            row_next = row + 8'd1;
          end
        end
      end
      default: begin
        phase_next = PH_WIDTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WIDTH;
      width_reg    <= 8'd0;
      height_reg   <= 8'd0;
      key_reg      <= 4'd0;
      column       <= 9'd0;
      row          <= 8'd0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        width_reg  <= width_reg_next;
        height_reg <= height_reg_next;
        key_reg    <= key_reg_next;
        column     <= column_next;
        row        <= row_next;
      end
      if (accept) begin
        result_valid <= emit;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind               <= res_kind;
      run_column         <= res_column;
      run_row            <= res_row;
      run_length         <= res_length;
      pixel_color        <= res_color;
      cel_width          <= width_reg_next;
      cel_height         <= height_reg_next;
      mirror_flag        <= res_mflag;
      mirror_source_loop <= res_mloop;
      cel_done           <= res_done;
    end
  end

  a_column_saturates: assert property (@(posedge clk) disable iff (rst)
    column <= COLUMN_LIMIT)
    else $error("column counter passed its limit");

  a_run_within_width: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_RUN |->
      ({1'b0, run_column} + {1'b0, run_length}) <= {1'b0, cel_width})
    else $error("run extends past the cel width");

  a_no_empty_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_RUN && !cel_done |-> run_length != 8'd0)
    else $error("empty run word emitted");

  a_done_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && emit && res_done |=> phase == PH_WIDTH && column == 9'd0)
    else $error("decoder did not return to the width byte after a cel");

endmodule
